// ===== sv/iaobf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the accelerometer offset and low-pass filter block.
package iaobf_pkg;

  localparam int NUM_AXES       = 3;
  localparam int OFFSET_W       = 16;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 30;
  localparam int HIST_W         = 48;
  localparam int HIST_FRAC      = 16;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = 2;
  localparam int FIFO_CNT_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 4'd0,
    REG_OFFSET_Y = 4'd1,
    REG_OFFSET_Z = 4'd2,
    REG_COEF_B0  = 4'd3,
    REG_COEF_A1  = 4'd4,
    REG_COEF_A2  = 4'd5,
    REG_CAL_EN   = 4'd6,
    REG_FLT_EN   = 4'd7
  } iaobf_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } iaobf_coef_t;

  typedef struct packed {
    logic a_vld;
    logic c_vld;
    logic cal_en;
    logic flt_en;
  } iaobf_ctl_t;

endpackage

// ===== sv/iaobf_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: sample requests, result requests and register writes.
interface iaobf_in_if #(parameter int SAMPLE_WIDTH = 16) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [SAMPLE_WIDTH-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

interface iaobf_out_if #(parameter int SAMPLE_WIDTH = 16) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] result_x;
  logic signed [SAMPLE_WIDTH-1:0] result_y;
  logic signed [SAMPLE_WIDTH-1:0] result_z;

  modport source (output valid, output result_x, output result_y, output result_z,
                  input ready);
  modport sink (input valid, input result_x, input result_y, input result_z,
                output ready);
endinterface

interface iaobf_cfg_if import iaobf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/imu_accel_offset_butterworth_filter_core.sv =====
`timescale 1ns / 1ps
// Top level: register file, per-axis lanes, stage control and result merge.
//
// Each request carries one sample per axis; the block optionally removes a per-axis
// offset (saturating) and optionally runs each axis through a second-order low-pass
// biquad, one lane per axis working side by side. A new request is accepted only after
// the last one has left the feedback stages: the calibrated sample is registered, then
// the recursion goes multiply, align and sum/saturate, and the output history must be
// written before the next request reaches the multipliers. The result is written into
// a 4-entry queue after the sum/saturate stage, so requests keep flowing while results
// are stalled, until the queue and the stages in flight hold 4 requests.
// Register writes are taken every cycle.
module imu_accel_offset_butterworth_filter_core import iaobf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  iaobf_in_if.sink   in_ch,
  iaobf_out_if.source out_ch,
  iaobf_cfg_if.sink  cfg_ch
);

  logic signed [OFFSET_W-1:0]     offset_r [NUM_AXES];
  iaobf_coef_t                    coef_r;
  logic                           cal_en_r, flt_en_r;
  logic                           a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic                           acc, room;
  iaobf_ctl_t                     ctl;
  logic signed [SAMPLE_WIDTH-1:0] smp [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] res [NUM_AXES];

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !a_vld_r && !b_vld_r && !c_vld_r && room;
  assign acc          = in_ch.valid && in_ch.ready;

  assign smp[0] = in_ch.sample_x;
  assign smp[1] = in_ch.sample_y;
  assign smp[2] = in_ch.sample_z;

  always_comb begin
    ctl.a_vld  = a_vld_r;
    ctl.c_vld  = c_vld_r;
    ctl.cal_en = cal_en_r;
    ctl.flt_en = flt_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0] <= '0;
      offset_r[1] <= '0;
      offset_r[2] <= '0;
      coef_r      <= '0;
      cal_en_r    <= 1'b0;
      flt_en_r    <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (iaobf_reg_e'(cfg_ch.index))
        REG_OFFSET_X: offset_r[0] <= cfg_ch.data[OFFSET_W-1:0];
        REG_OFFSET_Y: offset_r[1] <= cfg_ch.data[OFFSET_W-1:0];
        REG_OFFSET_Z: offset_r[2] <= cfg_ch.data[OFFSET_W-1:0];
        REG_COEF_B0:  coef_r.b0   <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_A1:  coef_r.a1   <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_A2:  coef_r.a2   <= cfg_ch.data[COEF_W-1:0];
        REG_CAL_EN:   cal_en_r    <= cfg_ch.data[0];
        REG_FLT_EN:   flt_en_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    iaobf_lane #(.SW(SAMPLE_WIDTH)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .coef   (coef_r),
      .offset (offset_r[g]),
      .sample (smp[g]),
      .result (res[g])
    );
  end

  iaobf_merge #(.SW(SAMPLE_WIDTH)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .wr     (d_vld_r),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_one_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({a_vld_r, b_vld_r, c_vld_r}))
    else $error("more than one request inside the feedback stages");

  a_no_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready ##1 !in_ch.ready ##1 !in_ch.ready)
    else $error("request accepted before output history was written");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |=> out_ch.valid)
    else $error("finished result missing from the queue");
`endif

endmodule

// ===== sv/iaobf_lane.sv =====
`timescale 1ns / 1ps
// One axis lane: offset removal and direct-form-I biquad with its own history.
module iaobf_lane import iaobf_pkg::*; #(
  parameter int SW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iaobf_ctl_t               ctl,
  input  iaobf_coef_t              coef,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic signed [SW-1:0]     sample,
  output logic signed [SW-1:0]     result
);

  localparam int DW   = ((SW > OFFSET_W) ? SW : OFFSET_W) + 1;
  localparam int SW2  = SW + 2;
  localparam int PBW  = SW2 + COEF_W;
  localparam int PHW  = 2 * COEF_W;
  localparam int PLW  = COEF_W + HIST_FRAC + 1;
  localparam int FBW  = PHW + 1;
  localparam int SUMW = FBW + 2;
  localparam int QW   = HIST_W - HIST_FRAC + 1;
  localparam int FF_SH = COEF_FRAC_BITS - HIST_FRAC;

  logic signed [DW-1:0]      diff;
  logic signed [SW-1:0]      v_nxt;
  logic signed [SW2-1:0]     s;
  logic signed [HIST_W-HIST_FRAC-1:0] yh0, yh1;
  logic signed [HIST_FRAC:0] yl0, yl1;
  logic signed [PBW-1:0]     ff_nxt;
  logic signed [FBW-1:0]     fb1_nxt, fb2_nxt;
  logic signed [SUMW-1:0]    sum;
  logic signed [HIST_W-1:0]  y_nxt;
  logic signed [QW-1:0]      q;
  logic signed [SW-1:0]      filt;

  logic signed [SW-1:0]      v_a_r, v_b_r, v_c_r, v_d_r;
  logic signed [SW-1:0]      x0_r, x1_r;
  logic signed [HIST_W-1:0]  y0_r, y1_r, y_d_r;
  logic signed [PBW-1:0]     pb_b_r, ff_c_r;
  logic signed [PHW-1:0]     p1h_b_r, p2h_b_r;
  logic signed [PLW-1:0]     p1l_b_r, p2l_b_r;
  logic signed [FBW-1:0]     fb1_c_r, fb2_c_r;

  always_comb begin
    diff = DW'(sample) - DW'(offset);
    if (&diff[DW-1:SW-1] || ~|diff[DW-1:SW-1]) begin
      v_nxt = diff[SW-1:0];
    end else if (diff[DW-1]) begin
      v_nxt = {1'b1, {(SW-1){1'b0}}};
    end else begin
      v_nxt = {1'b0, {(SW-1){1'b1}}};
    end
    if (!ctl.cal_en) begin
      v_nxt = sample;
    end
  end

  always_comb begin
    s   = SW2'(v_a_r) + (SW2'(x0_r) <<< 1) + SW2'(x1_r);
    yh0 = $signed(y0_r[HIST_W-1:HIST_FRAC]);
    yh1 = $signed(y1_r[HIST_W-1:HIST_FRAC]);
    yl0 = $signed({1'b0, y0_r[HIST_FRAC-1:0]});
    yl1 = $signed({1'b0, y1_r[HIST_FRAC-1:0]});
  end

  always_comb begin
    ff_nxt  = pb_b_r >>> FF_SH;
    fb1_nxt = (FBW'(p1h_b_r) + FBW'(p1l_b_r >>> HIST_FRAC)) >>> FF_SH;
    fb2_nxt = (FBW'(p2h_b_r) + FBW'(p2l_b_r >>> HIST_FRAC)) >>> FF_SH;
  end

  always_comb begin
    sum = SUMW'(ff_c_r) - SUMW'(fb1_c_r) - SUMW'(fb2_c_r);
    if (&sum[SUMW-1:HIST_W-1] || ~|sum[SUMW-1:HIST_W-1]) begin
      y_nxt = sum[HIST_W-1:0];
    end else if (sum[SUMW-1]) begin
      y_nxt = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  always_comb begin
    q = QW'($signed(y_d_r[HIST_W-1:HIST_FRAC]))
        + {{(QW-1){1'b0}}, y_d_r[HIST_W-1] & (|y_d_r[HIST_FRAC-1:0])};
    if (&q[QW-1:SW-1] || ~|q[QW-1:SW-1]) begin
      filt = q[SW-1:0];
    end else if (q[QW-1]) begin
      filt = {1'b1, {(SW-1){1'b0}}};
    end else begin
      filt = {1'b0, {(SW-1){1'b1}}};
    end
    result = ctl.flt_en ? filt : v_d_r;
  end

  always_ff @(posedge clk) begin
    v_a_r   <= v_nxt;
    v_b_r   <= v_a_r;
    pb_b_r  <= PBW'(coef.b0) * PBW'(s);
    p1h_b_r <= PHW'(coef.a1) * PHW'(yh0);
    p1l_b_r <= PLW'(coef.a1) * PLW'(yl0);
    p2h_b_r <= PHW'(coef.a2) * PHW'(yh1);
    p2l_b_r <= PLW'(coef.a2) * PLW'(yl1);
    v_c_r   <= v_b_r;
    ff_c_r  <= ff_nxt;
    fb1_c_r <= fb1_nxt;
    fb2_c_r <= fb2_nxt;
    v_d_r   <= v_c_r;
    y_d_r   <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      x1_r <= '0;
      y0_r <= '0;
      y1_r <= '0;
    end else begin
      if (ctl.a_vld && ctl.flt_en) begin
        x1_r <= x0_r;
        x0_r <= v_a_r;
      end
      if (ctl.c_vld && ctl.flt_en) begin
        y1_r <= y0_r;
        y0_r <= y_nxt;
      end
    end
  end

endmodule

// ===== sv/iaobf_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: joins the lane results into one result request and queues it.
module iaobf_merge import iaobf_pkg::*; #(
  parameter int SW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic                 wr,
  input  logic signed [SW-1:0] res [NUM_AXES],
  output logic                 room,
  iaobf_out_if.source          out_ch
);

  logic signed [SW-1:0]  mem_r [FIFO_DEPTH][NUM_AXES];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fill_r, infl_r;
  logic                  pop;

  assign out_ch.valid    = (fill_r != '0);
  assign pop             = out_ch.valid && out_ch.ready;
  assign out_ch.result_x = mem_r[rd_ptr_r][0];
  assign out_ch.result_y = mem_r[rd_ptr_r][1];
  assign out_ch.result_z = mem_r[rd_ptr_r][2];
  assign room            = (infl_r < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (wr) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        mem_r[wr_ptr_r][k] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      infl_r   <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + FIFO_CNT_W'(wr) - FIFO_CNT_W'(pop);
      infl_r <= infl_r + FIFO_CNT_W'(acc) - FIFO_CNT_W'(pop);
    end
  end

endmodule
